// ===== hdl/radix_integer_to_ascii_unit_macros.svh =====
// Assertion macros for the converter's top-level module.
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define RITA_ASSERT_CLK(label, clk_i, rstn_i, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Concurrent check on the module's clk and rst_n.
`define RITA_ASSERT(label, prop, msg) `RITA_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ===== hdl/rita_pkg.sv =====
// Types, constants and digit encoding for the radix integer-to-ASCII converter.
`default_nettype none
package rita_pkg;

  localparam int NUMBER_W    = 64;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;
  localparam int COUNT_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A_LC   = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN   = 8'd10;

  // Divider status towards the sequencer
  typedef struct packed {
    logic               done;
    logic               zero;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

  // Map a digit value to '0'-'9' or 'a'-'f'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d <= DIGIT_NINE) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A_LC + dx - DIGIT_TEN;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rita_divider.sv =====
// Bit-serial restoring divider of a value by a small radix, one quotient bit per cycle.
`default_nettype none
module rita_divider
  import rita_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [RADIX_W-1:0]     radix,
  output logic      [VALUE_WIDTH-1:0] quotient,
  output div_stat_t                   stat
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [RADIX_W-1:0]     trial;
  logic [RADIX_W-1:0]     diff;
  logic                   ge;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign trial = {rem_r, q_r[VALUE_WIDTH-1]};
  assign ge    = trial >= radix;
  assign diff  = trial - radix;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_WIDTH);
      run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt   = {q_r[VALUE_WIDTH-2:0], ge};
      rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold datapath; control cleared on reset
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.done = done_r;
  assign stat.zero = ~|q_r;
  assign stat.rem  = rem_r;

endmodule
`default_nettype wire

// ===== hdl/rita_digit_store.sv =====
// Digit memory: one write port, one registered read port.
`default_nettype none
module rita_digit_store
  import rita_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [STORE_AW-1:0] waddr,
  input  wire logic [DIGIT_W-1:0]  wdata,
  input  wire logic [STORE_AW-1:0] raddr,
  output logic      [DIGIT_W-1:0]  rdata
);

  logic [DIGIT_W-1:0] mem [STORE_DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  // Write a digit; read one back through the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/radix_integer_to_ascii_unit.sv =====
// Top level of the radix integer-to-ASCII converter.
//
// Usage: program the base through cfg_we/cfg_wdata (reset value 10) while the
// block is idle. Raise start with in_number while busy is low; the value is
// taken at that edge. The block then repeats a division by the base on a
// bit-serial divider, one quotient bit per cycle, storing each remainder as a
// digit until the quotient is zero; the characters then leave most significant
// first, one beat per cycle on out_strobe, with out_last on the final one.
// The longest conversion is base 2 with all ones.
// A base outside 2 to 16 gives a single beat with out_error and out_last set
// and out_digit_char zero, in the cycle after start.
// The receiver cannot stall: each beat is on the outputs for one cycle only.
// Reset (rst_n low, synchronous) returns the sequencer to idle and the base
// register to 10; the digit memory needs no clearing.
`default_nettype none
`include "radix_integer_to_ascii_unit_macros.svh"
module radix_integer_to_ascii_unit
  import rita_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [RADIX_W-1:0]  cfg_wdata,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [NUMBER_W-1:0] in_number,
  output logic                     out_strobe,
  output logic      [CHAR_W-1:0]   out_digit_char,
  output logic                     out_last,
  output logic                     out_error
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [RADIX_W-1:0]      radix_r;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [STORE_AW-1:0]     ptr_r, ptr_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_error_r, out_error_nxt;

  logic                    radix_ok;
  logic                    accept;
  logic                    last_slot;
  logic                    div_load;
  logic [VALUE_WIDTH-1:0]  div_dividend;
  logic [VALUE_WIDTH-1:0]  div_quot;
  div_stat_t               div_stat;
  logic                    st_we;
  logic [DIGIT_W-1:0]      st_rdata;

  assign radix_ok  = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign accept    = start && (state_r == S_IDLE);
  assign last_slot = count_r == COUNT_W'(STORE_DEPTH - 1);
  assign st_we     = (state_r == S_DIVIDE) && div_stat.done;

  // Restart the divider on a new value with a valid base, or on a non-zero quotient while store slots remain
  assign div_load = (accept && radix_ok) ||
                    (st_we && !div_stat.zero && !last_slot);
  assign div_dividend = (state_r == S_IDLE) ? in_number[VALUE_WIDTH-1:0] : div_quot;

  rita_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dividend),
    .radix    (radix_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  rita_digit_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[STORE_AW-1:0]),
    .wdata (div_stat.rem),
    .raddr (ptr_r),
    .rdata (st_rdata)
  );

  // Sequence: divide until the quotient is zero or the store is full, then read digits back downwards
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    out_strobe_nxt = 1'b0;
    out_last_nxt   = out_last_r;
    out_error_nxt  = out_error_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (radix_ok) begin
            state_nxt = S_DIVIDE;
            count_nxt = '0;
          end else begin
            count_nxt      = '0;
            out_strobe_nxt = 1'b1;
            out_last_nxt   = 1'b1;
            out_error_nxt  = 1'b1;
          end
        end
      end
      S_DIVIDE: begin
        if (div_stat.done) begin
          count_nxt = count_r + COUNT_W'(1);
          if (div_stat.zero || last_slot) begin
            state_nxt = S_EMIT;
            ptr_nxt   = count_r[STORE_AW-1:0];
          end
        end
      end
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_error_nxt  = 1'b0;
        out_last_nxt   = ptr_r == '0;
        ptr_nxt        = ptr_r - STORE_AW'(1);
        if (ptr_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and registered outputs
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radix_r      <= RADIX_RESET;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_strobe     = out_strobe_r;
  assign out_last       = out_last_r;
  assign out_error      = out_error_r;
  assign out_digit_char = out_error_r ? '0 : digit_to_ascii(st_rdata);

  `RITA_ASSERT(a_err_is_last, out_strobe_r && out_error_r |-> out_last_r, "error beat not last")
  `RITA_ASSERT(a_bad_radix_beat, accept && !radix_ok |=> out_strobe_r && out_error_r, "error lost")
  `RITA_ASSERT(a_done_in_divide, div_stat.done |-> state_r == S_DIVIDE, "stray divider done")
  `RITA_ASSERT(a_store_bound, st_we |-> count_r < COUNT_W'(STORE_DEPTH), "store overrun")

endmodule
`default_nettype wire

// ===== tb/sv/radix_integer_to_ascii_unit_checker.sv =====
// Checker for the radix converter: tracks the base, predicts the characters and compares beats.
`default_nettype none
module radix_integer_to_ascii_unit_checker
  import rita_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [RADIX_W-1:0]  cfg_wdata,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [NUMBER_W-1:0] in_number,
  input  wire logic                out_strobe,
  input  wire logic [CHAR_W-1:0]   out_digit_char,
  input  wire logic                out_last,
  input  wire logic                out_error,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              error;
  } char_beat_t;

  localparam logic [NUMBER_W-1:0] VALUE_MASK = {NUMBER_W{1'b1}} >> (NUMBER_W - VALUE_WIDTH);

  logic [RADIX_W-1:0] base_reg;
  char_beat_t         expected_chars[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    base_reg   = RADIX_RESET;
  end

  // Divide repeatedly, then queue the digits most significant first; a bad base queues one error beat
  task automatic predict_string(input logic [NUMBER_W-1:0] number);
    logic [DIGIT_W-1:0]  digits [STORE_DEPTH];
    logic [NUMBER_W-1:0] quot;
    logic [NUMBER_W-1:0] base;
    int                  n;
    char_beat_t          beat;
    if (base_reg < RADIX_MIN || base_reg > RADIX_MAX) begin
      // Bad base: one error beat, no digits
      beat.digit_char = '0;
      beat.last       = 1'b1;
      beat.error      = 1'b1;
      expected_chars.push_back(beat);
    end else begin
      base = {{(NUMBER_W-RADIX_W){1'b0}}, base_reg};
      quot = number & VALUE_MASK;
      n    = 0;
      do begin
        digits[n] = DIGIT_W'(quot % base);
        quot      = quot / base;
        n++;
      end while (quot != 0 && n < STORE_DEPTH);
      for (int k = n - 1; k >= 0; k--) begin
        if (digits[k] < 4'd10) begin
          beat.digit_char = CHAR_ZERO + digits[k];
        end else begin
          beat.digit_char = CHAR_A_LC + digits[k] - 8'd10;
        end
        beat.last  = (k == 0);
        beat.error = 1'b0;
        expected_chars.push_back(beat);
      end
    end
  endtask

  // Compare each result beat with the oldest expectation; track the base register
  always @(posedge clk) begin
    int         errs;
    char_beat_t want;
    errs = 0;
    if (!rst_n) begin
      base_reg <= RADIX_RESET;
      expected_chars.delete();
    end else begin
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat char %h last %b error %b", $time,
                   out_digit_char, out_last, out_error);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %h actual %h", $time,
                     want.digit_char, out_digit_char);
            errs++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_last);
            errs++;
          end
          if (out_error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time, want.error, out_error);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        predict_string(in_number);
      end
      if (cfg_we) begin
        base_reg <= cfg_wdata;
      end
    end
    fail_count <= fail_count + errs;
    pending    <= expected_chars.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/radix_integer_to_ascii_unit_test.sv =====
// Testbench top for the radix converter: drives numbers and base settings, gives the verdict.
`default_nettype none
module radix_integer_to_ascii_unit_test;
  import rita_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [RADIX_W-1:0]  cfg_wdata = RADIX_RESET;
  logic                start     = 1'b0;
  logic [NUMBER_W-1:0] in_number = '0;
  logic                busy;
  logic                out_strobe;
  logic [CHAR_W-1:0]   out_digit_char;
  logic                out_last;
  logic                out_error;
  int                  fail_count;
  int                  pending;
  int                  idle_pct     = 25;
  int                  stall_cycles = 0;

  radix_integer_to_ascii_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_number      (in_number),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  radix_integer_to_ascii_unit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_number      (in_number),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_error      (out_error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #10 clk = ~clk;

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one number until accepted, dropping start on random idle cycles
  task automatic send_number(input logic [NUMBER_W-1:0] num);
    logic accepted;
    accepted = 1'b0;
    while (!accepted) begin
      if ($urandom_range(99) < idle_pct) begin
        start     <= 1'b0;
        in_number <= {$urandom, $urandom};
      end else begin
        start     <= 1'b1;
        in_number <= num;
      end
      @(posedge clk);
      accepted = start && !busy;
    end
  endtask

  // Hold off until every expected beat has arrived and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short values to keep digit counts low, a quarter at full width
  function automatic logic [NUMBER_W-1:0] random_number();
    logic [NUMBER_W-1:0] v;
    int                  width;
    v = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      width = $urandom_range(24);
      if (width == 0) begin
        v = '0;
      end else begin
        v = v & ({NUMBER_W{1'b1}} >> (NUMBER_W - width));
      end
    end
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(4) == 0) begin
      if ($urandom_range(1) == 1) begin
        return RADIX_W'($urandom_range(1));
      end
      return RADIX_W'($urandom_range(31, 17));
    end
    return RADIX_W'($urandom_range(16, 2));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset base of ten: zero, single digits, the carry to two digits, full range
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'd10000000000000000000);

    // Base two: longest string and top bit alone
    set_radix(5'd2);
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);

    // Base sixteen: every letter digit
    set_radix(5'd16);
    send_number(64'hFEDC_BA98_7654_3210);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'h0123_4567_89AB_CDEF);

    // Bases out of range give a lone error beat
    set_radix(5'd0);
    send_number(64'd5);
    set_radix(5'd1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    set_radix(5'd17);
    send_number(64'd0);
    set_radix(5'd31);
    send_number(64'h5555_AAAA_5555_AAAA);

    set_radix(5'd3);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'd0);

    // Random phases: moderate idling, heavy idling, then back to back
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_radix(random_radix());
      idle_pct = (p < 5) ? 25 : (p < 10) ? 68 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_number(random_number());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/rita_pkg.sv
hdl/rita_divider.sv
hdl/rita_digit_store.sv
hdl/radix_integer_to_ascii_unit.sv
tb/sv/radix_integer_to_ascii_unit_checker.sv
tb/sv/radix_integer_to_ascii_unit_test.sv
